### rtl/assert_macros.svh
// Assertion macros shared by the checker files of this block.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

### rtl/rcbc_pkg.sv
// Shared types, character constants and the report formatter of the relay controller.
// No dependencies.
package rcbc_pkg;

   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_STAR  = 8'h2A;
   localparam logic [7:0] CHAR_C     = 8'h63;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0D;

   localparam logic [30:0] TOK_MAX = 31'h7FFF_FFFF;
   // TOK_MAX / 10 modulo 256, and whether TOK_MAX % 10 is nonzero
   localparam logic [7:0] SAT_QUOT  = 8'hCC;
   localparam logic       SAT_UNITS = 1'b1;

   // relay codes carried by a command token
   localparam logic [7:0] CODE_RELAY8 = 8'd1;
   localparam logic [7:0] CODE_RELAY7 = 8'd2;
   localparam logic [7:0] CODE_RELAY6 = 8'd3;
   localparam logic [7:0] CODE_RELAY5 = 8'd4;

   localparam logic [3:0] RELAY_RESET = 4'd5;
   localparam logic [3:0] REPORT_LAST = 4'd8;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      logic       last;
      logic [3:0] relays;
   } job_type;

   typedef struct packed {
      logic    valid;
      job_type job;
   } push_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic [7:0] digit_char(input logic b);
      return {7'b0011000, b};
   endfunction

   function automatic logic [7:0] report_char(input logic [3:0] relays, input logic [3:0] pos);
      logic [7:0] ch;
      case (pos)
         4'd0: ch = CHAR_C;
         4'd1: ch = digit_char(relays[3]);
         4'd3: ch = digit_char(relays[2]);
         4'd5: ch = digit_char(relays[1]);
         4'd7: ch = digit_char(relays[0]);
         4'd2, 4'd4, 4'd6: ch = CHAR_SLASH;
         default: ch = CHAR_STAR;
      endcase
      return ch;
   endfunction

endpackage

### rtl/rcbc_front.sv
// Front end of the relay controller: accepts words, parses command tokens,
// scans button events and pushes report jobs. Depends on rcbc_pkg.
module rcbc_front import rcbc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             req_mode,
   input  logic [7:0]       req_rx_byte,
   input  logic [3:0]       req_button_levels,
   input  queue_status_type q_status,
   output push_type         push
);

   typedef enum logic [3:0] {
      PH_START  = 4'b0001,
      PH_DIGITS = 4'b0010,
      PH_DONE   = 4'b0100,
      PH_NEG    = 4'b1000
   } phase_type;

   logic [3:0]  relay_ff, relay_in;
   logic [30:0] value_ff, value_in;
   logic [7:0]  quot_ff, quot_in;
   logic        units_nz_ff, units_nz_in;
   phase_type   phase_ff, phase_in;
   logic [3:0]  latch_ff, latch_in;
   logic [3:0]  pend_ff, pend_in;

   logic        accept, is_term, is_digit, is_white, take_char, sat;
   logic [7:0]  diff;
   logic [3:0]  d, sel, hi, rest;
   logic [34:0] prod;

   assign req_ready = (pend_ff == 4'b0000) && !q_status.full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      is_term  = (req_rx_byte == CHAR_SLASH) || (req_rx_byte == CHAR_STAR);
      is_digit = (req_rx_byte >= CHAR_ZERO) && (req_rx_byte <= CHAR_NINE);
      is_white = (req_rx_byte == CHAR_SPACE) ||
                 ((req_rx_byte >= CHAR_TAB) && (req_rx_byte <= CHAR_CR));
      diff     = req_rx_byte - CHAR_ZERO;
      d        = diff[3:0];
      // value * 10 + digit, checked against the saturation limit
      prod     = {1'b0, value_ff, 3'b000} + {3'b000, value_ff, 1'b0} + {31'b0, d};
      sat      = prod > {4'b0000, TOK_MAX};

      case (quot_ff)
         CODE_RELAY8: sel = 4'b1000;
         CODE_RELAY7: sel = 4'b0100;
         CODE_RELAY6: sel = 4'b0010;
         CODE_RELAY5: sel = 4'b0001;
         default:     sel = 4'b0000;
      endcase

      // highest pending button first
      if (pend_ff[3])      hi = 4'b1000;
      else if (pend_ff[2]) hi = 4'b0100;
      else if (pend_ff[1]) hi = 4'b0010;
      else                 hi = {3'b000, pend_ff[0]};
      rest = pend_ff & ~hi;
   end

   always_comb begin
      relay_in    = relay_ff;
      value_in    = value_ff;
      quot_in     = quot_ff;
      units_nz_in = units_nz_ff;
      phase_in    = phase_ff;
      latch_in    = latch_ff;
      pend_in     = pend_ff;
      push        = '0;
      take_char   = 1'b0;

      if (accept) begin
         if (!req_mode) begin
            if (is_term) begin
               if ((phase_ff != PH_NEG) && (sel != 4'b0000)) begin
                  relay_in        = units_nz_ff ? (relay_ff | sel) : (relay_ff & ~sel);
                  push.valid      = 1'b1;
                  push.job.last   = 1'b1;
                  push.job.relays = relay_in;
               end
               value_in    = '0;
               quot_in     = '0;
               units_nz_in = 1'b0;
               phase_in    = PH_START;
            end else begin
               case (phase_ff)
                  PH_START: begin
                     if (req_rx_byte == CHAR_MINUS) begin
                        phase_in = PH_NEG;
                     end else if (!is_white) begin
                        take_char = 1'b1;
                     end
                  end
                  PH_DIGITS: take_char = 1'b1;
                  default:   take_char = 1'b0;
               endcase
               if (take_char) begin
                  if (is_digit) begin
                     phase_in    = PH_DIGITS;
                     value_in    = sat ? TOK_MAX : prod[30:0];
                     // the quotient by ten is the value before this digit
                     quot_in     = sat ? SAT_QUOT : value_ff[7:0];
                     units_nz_in = sat ? SAT_UNITS : (d != 4'd0);
                  end else begin
                     phase_in = PH_DONE;
                  end
               end
            end
         end else begin
            pend_in  = ~req_button_levels & ~latch_ff;
            latch_in = ~req_button_levels;
         end
      end else if ((pend_ff != 4'b0000) && !q_status.full) begin
         relay_in        = relay_ff ^ hi;
         pend_in         = rest;
         push.valid      = 1'b1;
         push.job.last   = (rest == 4'b0000);
         push.job.relays = relay_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         relay_ff    <= RELAY_RESET;
         value_ff    <= '0;
         quot_ff     <= '0;
         units_nz_ff <= 1'b0;
         phase_ff    <= PH_START;
         latch_ff    <= '0;
         pend_ff     <= '0;
      end else begin
         relay_ff    <= relay_in;
         value_ff    <= value_in;
         quot_ff     <= quot_in;
         units_nz_ff <= units_nz_in;
         phase_ff    <= phase_in;
         latch_ff    <= latch_in;
         pend_ff     <= pend_in;
      end
   end

endmodule

### rtl/rcbc_queue.sv
// Short job queue between the front and back ends of the relay controller.
// Depends on rcbc_pkg.
module rcbc_queue import rcbc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  push_type         push,
   input  logic             pop,
   output job_type          head,
   output queue_status_type q_status
);

   job_type               mem [QUEUE_DEPTH];
   job_type               head_ff;
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]     count_ff, count_in;

   assign head           = head_ff;
   assign q_status.full  = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign q_status.empty = (count_ff == '0);

   always_comb begin
      wr_ptr_in = push.valid ? wr_ptr_ff + QUEUE_AW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QUEUE_AW'(1) : rd_ptr_ff;
      count_in  = count_ff + (QUEUE_AW+1)'(push.valid) - (QUEUE_AW+1)'(pop);
   end

   // register the entry at the next read pointer; forward a word written there this cycle
   always_ff @(posedge clock) begin
      if (push.valid) begin
         mem[wr_ptr_ff] <= push.job;
      end
      if (push.valid && (wr_ptr_ff == rd_ptr_in)) begin
         head_ff <= push.job;
      end else begin
         head_ff <= mem[rd_ptr_in];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### rtl/rcbc_back.sv
// Back end of the relay controller: turns each queued job into a 9-word report.
// Depends on rcbc_pkg.
module rcbc_back import rcbc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  job_type          head,
   input  queue_status_type q_status,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [7:0]       rsp_tx_byte,
   output logic             rsp_last,
   output logic [3:0]       rsp_relay_states
);

   logic       active_ff, active_in;
   logic [3:0] pos_ff, pos_in;
   job_type    job_ff, job_in;
   logic       done;

   assign rsp_valid        = active_ff;
   assign rsp_tx_byte      = report_char(job_ff.relays, pos_ff);
   assign rsp_last         = job_ff.last && (pos_ff == REPORT_LAST);
   assign rsp_relay_states = job_ff.relays;

   assign done = active_ff && rsp_ready && (pos_ff == REPORT_LAST);
   assign pop  = (!active_ff || done) && !q_status.empty;

   always_comb begin
      active_in = active_ff;
      pos_in    = pos_ff;
      job_in    = job_ff;
      if (pop) begin
         active_in = 1'b1;
         pos_in    = '0;
         job_in    = head;
      end else if (done) begin
         active_in = 1'b0;
      end else if (active_ff && rsp_ready) begin
         pos_in = pos_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      if (reset) begin
         active_ff <= 1'b0;
         pos_ff    <= '0;
      end else begin
         active_ff <= active_in;
         pos_ff    <= pos_in;
      end
   end

endmodule

### rtl/relay_command_and_button_control.sv
// A report for an accepted terminator word passes the queue and the back end's job register
// before its first word leaves; a button sample first passes the front end's pending register.
// Throughput: one serial word per cycle while the queue has room; a button sample holds ready
// low until each button that fires is pushed, one toggle per cycle while the queue has room.
// Reports leave at one word per ready cycle, 9 words each; the back end bounds the sustained rate.
// Reset (synchronous): relays 8..5 = 0101, empty token, button latches clear, queue empty.
module relay_command_and_button_control import rcbc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_mode,
   input  logic [7:0] req_rx_byte,
   input  logic [3:0] req_button_levels,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_tx_byte,
   output logic       rsp_last,
   output logic [3:0] rsp_relay_states
);

   // Front end: parse tokens, toggle relays on new presses, push one job per relay command or toggle.
   push_type         push;
   // Queue status and head job; the back end drains it on its own schedule.
   queue_status_type q_status;
   job_type          head;
   logic             pop;

   rcbc_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_mode          (req_mode),
      .req_rx_byte       (req_rx_byte),
      .req_button_levels (req_button_levels),
      .q_status          (q_status),
      .push              (push)
   );

   // Hold up to four report jobs so a burst of button toggles need not wait for the back end.
   rcbc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .pop      (pop),
      .head     (head),
      .q_status (q_status)
   );

   // Back end: advance one report word per accepted output word, drop the job after '*'.
   rcbc_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head             (head),
      .q_status         (q_status),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_tx_byte      (rsp_tx_byte),
      .rsp_last         (rsp_last),
      .rsp_relay_states (rsp_relay_states)
   );

endmodule

### rtl/rcbc_checker.sv
// Port-level checks of the relay controller, bound to the top level.
// Depends on rcbc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rcbc_checker import rcbc_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_tx_byte,
   input logic       rsp_last,
   input logic [3:0] rsp_relay_states
);

   logic rsp_fire, rsp_stall, mid_report, hdr_fire;
   assign rsp_fire   = rsp_valid && rsp_ready;
   assign rsp_stall  = rsp_valid && !rsp_ready;
   assign mid_report = rsp_fire && (rsp_tx_byte != CHAR_STAR);
   assign hdr_fire   = rsp_fire && (rsp_tx_byte == CHAR_C);

   // a stalled output word holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable({rsp_tx_byte, rsp_last}))

   // inside a report the next word follows at once with the same relay states
   `ASSERT_NEXT(a_report_cont, clock, reset, mid_report, rsp_valid && $stable(rsp_relay_states))

   // the final word of a run closes a report
   `ASSERT_IMPLY(a_last_star, clock, reset, rsp_valid && rsp_last, rsp_tx_byte == CHAR_STAR)

   // the word after the header reports relay 8
   `ASSERT_NEXT(a_relay8_digit, clock, reset, hdr_fire, rsp_tx_byte == digit_char(rsp_relay_states[3]))

endmodule

bind relay_command_and_button_control rcbc_checker u_rcbc_checker (.*);

### tb/tb.sv
// Self-checking testbench for relay_command_and_button_control: serial command tokens
// and button samples in, 9-word relay reports out. Depends on rcbc_pkg for characters.
// A scoreboard class predicts every report word and checks the stream in order.
module tb;
   import rcbc_pkg::*;

   localparam logic MODE_SERIAL = 1'b0;
   localparam logic MODE_BUTTON = 1'b1;

   localparam int RESET_CYCLES = 11;
   localparam int RANDOM_WORDS = 500;
   localparam int DRAIN_CYCLES = 20;
   // worst case is far below this for 500 words of up to 36 report words each
   localparam int CYCLE_LIMIT = 400_000;

   // stall pattern used by the receiver in its fixed-pattern mode
   localparam logic [7:0] READY_PATTERN = 8'b1100_1010;

   // one word of a relay report as it should leave the block
   typedef struct packed {
      logic [7:0] ch;
      logic       last;
      logic [3:0] relays;
   } report_word_type;

   // Predicts the report stream and checks the block's output against it in order.
   class relay_report_board;
      typedef enum logic [3:0] {
         TOK_START  = 4'b0001,
         TOK_DIGITS = 4'b0010,
         TOK_DONE   = 4'b0100,
         TOK_NEG    = 4'b1000
      } tok_phase_type;

      logic [3:0]      relays;
      logic [3:0]      latched;
      int unsigned     tok_val;
      tok_phase_type   phase;
      report_word_type expected[$];
      int              n_errors;
      int              n_checked;
      int              n_reports;

      function new();
         relays    = RELAY_RESET;
         latched   = 4'b0000;
         tok_val   = 0;
         phase     = TOK_START;
         n_errors  = 0;
         n_checked = 0;
         n_reports = 0;
      endfunction

      function int pending();
         return expected.size();
      endfunction

      // queue the 9 words that describe the current relay state
      function void push_report();
         logic [7:0] line [9];
         int k;
         line = '{CHAR_C, CHAR_ZERO + relays[3], CHAR_SLASH, CHAR_ZERO + relays[2],
                  CHAR_SLASH, CHAR_ZERO + relays[1], CHAR_SLASH, CHAR_ZERO + relays[0],
                  CHAR_STAR};
         for (k = 0; k < 9; k++) begin
            expected.push_back(report_word_type'{ch: line[k], last: 1'b0, relays: relays});
         end
         n_reports++;
      endfunction

      // advance the predicted state by one accepted word
      function void note_word(logic mode, logic [7:0] rx, logic [3:0] levels);
         int          base;
         int          b;
         int unsigned d;
         logic [31:0] quot;
         logic [7:0]  code;
         logic [3:0]  sel;
         base = expected.size();
         if (mode == MODE_SERIAL) begin
            if (rx != CHAR_SLASH && rx != CHAR_STAR) begin
               if (phase == TOK_START) begin
                  // blanks before the first digit are skipped, a minus disarms the token
                  if (!(rx == CHAR_SPACE || (rx >= CHAR_TAB && rx <= CHAR_CR))) begin
                     phase = (rx == CHAR_MINUS) ? TOK_NEG : TOK_DIGITS;
                  end
               end
               if (phase == TOK_DIGITS) begin
                  if (rx >= CHAR_ZERO && rx <= CHAR_NINE) begin
                     d = rx - CHAR_ZERO;
                     if (tok_val > (TOK_MAX - d) / 10) tok_val = TOK_MAX;
                     else tok_val = tok_val * 10 + d;
                  end else begin
                     phase = TOK_DONE;
                  end
               end
            end else begin
               if (phase != TOK_NEG) begin
                  quot = tok_val / 10;
                  code = quot[7:0];
                  if (code >= CODE_RELAY8 && code <= CODE_RELAY5) begin
                     sel = 4'b1000 >> (code - CODE_RELAY8);
                     if (tok_val % 10 != 0) relays = relays | sel;
                     else relays = relays & ~sel;
                     push_report();
                  end
               end
               tok_val = 0;
               phase   = TOK_START;
            end
         end else begin
            // scan button one (bit 3) down to button four; each new press toggles once
            for (b = 3; b >= 0; b--) begin
               if (!levels[b] && !latched[b]) begin
                  latched[b] = 1'b1;
                  relays[b]  = ~relays[b];
                  push_report();
               end else if (levels[b]) begin
                  latched[b] = 1'b0;
               end
            end
         end
         if (expected.size() > base) expected[expected.size() - 1].last = 1'b1;
      endfunction

      task report(string what);
         n_errors++;
         $display("MISMATCH @%0t: %s", $time, what);
      endtask

      task check_result(logic [7:0] tx, logic last, logic [3:0] rel);
         report_word_type want;
         if (expected.size() == 0) begin
            report($sformatf("report word %h with nothing expected", tx));
            return;
         end
         want = expected.pop_front();
         n_checked++;
         if (tx !== want.ch)
            report($sformatf("tx_byte %h, expected %h", tx, want.ch));
         if (last !== want.last)
            report($sformatf("last %b, expected %b (tx_byte %h)", last, want.last, want.ch));
         if (rel !== want.relays)
            report($sformatf("relay_states %b, expected %b", rel, want.relays));
      endtask
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic       req_mode = MODE_SERIAL;
   logic [7:0] req_rx_byte = 8'h00;
   logic [3:0] req_button_levels = 4'hF;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_tx_byte;
   logic       rsp_last;
   logic [3:0] rsp_relay_states;

   relay_report_board board = new();

   int cycle_count = 0;
   int words_sent  = 0;
   int burst_left  = 0;
   bit valid_up    = 0;
   int stall_mode  = 0;
   int stall_left  = 0;

   relay_command_and_button_control u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_rx_byte      (req_rx_byte),
      .req_button_levels(req_button_levels),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_tx_byte      (rsp_tx_byte),
      .rsp_last         (rsp_last),
      .rsp_relay_states (rsp_relay_states)
   );

   always #5 clock = ~clock;

   // Watchdog: end the run if the block stops moving.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TIMEOUT after %0d cycles, %0d report words still pending",
                  cycle_count, board.pending());
         $display("Test completed with failures");
         $finish;
      end
   end

   // Receiver: switch between always-ready, coin-flip, mostly-stalled and a fixed
   // pattern at random so stalls land on every report word.
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(0, 3);
         stall_left <= $urandom_range(30, 200);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= $urandom_range(0, 1);
         2: rsp_ready <= ($urandom_range(0, 3) == 0);
         default: rsp_ready <= READY_PATTERN[cycle_count % 8];
      endcase
   end

   // Check every report word the moment it is handed over.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check_result(rsp_tx_byte, rsp_last, rsp_relay_states);
   end

   // Present one word, hold it until accepted, then either keep the burst going
   // or drop valid for a random gap.
   task automatic put_word(logic mode, logic [7:0] rx, logic [3:0] levels);
      req_valid         <= 1'b1;
      req_mode          <= mode;
      req_rx_byte       <= rx;
      req_button_levels <= levels;
      valid_up = 1;
      do @(posedge clock); while (!req_ready);
      board.note_word(mode, rx, levels);
      words_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         valid_up = 0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         // mostly short bursts, now and then a long back-to-back stretch
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(0, 6);
      end
   endtask

   // serial byte; the button field is ignored here, so let it wander
   task automatic put_char(logic [7:0] c);
      put_word(MODE_SERIAL, c, 4'($urandom));
   endtask

   // Drop valid and hold off until every predicted report word has left the block.
   task automatic hold_until_drained();
      if (valid_up) begin
         req_valid <= 1'b0;
         valid_up = 0;
      end
      while (board.pending() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   // Build one command token: optional blanks, optional minus, digits unless the token is empty,
   // optional junk, terminator. Most tokens address a relay so the report path stays busy.
   task automatic send_token();
      logic [7:0]      chars[$];
      logic [7:0]      digits[$];
      logic [7:0]      c;
      longint unsigned val;
      longint unsigned wrap;
      int              kind;
      int              idx;
      int              n;
      kind = $urandom_range(0, 99);
      wrap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40) : 0;
      if (kind < 60)
         // relay command, sometimes with a code that only lands in 1..4 modulo 256
         val = (wrap * 256 + $urandom_range(1, 4)) * 10 + $urandom_range(0, 9);
      else if (kind < 66)
         val = 64'd2147483630 + $urandom_range(0, 40);
      else if (kind < 72)
         val = {$urandom, $urandom} % 64'd1_000_000_000_000;
      else
         val = $urandom_range(0, 99999);

      repeat ($urandom_range(0, 2)) begin
         idx = $urandom_range(0, 5);
         chars.push_back(idx == 5 ? CHAR_SPACE : CHAR_TAB + 8'(idx));
      end
      if ($urandom_range(0, 9) == 0) chars.push_back(CHAR_MINUS);
      // kind 90..99 leaves the digits out: empty token
      if (kind < 90) begin
         do begin
            digits.push_front(CHAR_ZERO + 8'(val % 10));
            val = val / 10;
         end while (val != 0);
         foreach (digits[i]) chars.push_back(digits[i]);
      end
      if ($urandom_range(0, 4) == 0) begin
         n = $urandom_range(1, 3);
         repeat (n) begin
            do c = 8'($urandom); while (c == CHAR_SLASH || c == CHAR_STAR);
            chars.push_back(c);
         end
      end
      chars.push_back($urandom_range(0, 1) ? CHAR_SLASH : CHAR_STAR);
      foreach (chars[i]) put_char(chars[i]);
   endtask

   initial begin
      int  pick;
      bit  paused;
      paused = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed part.
      // blanks (CR, VT) before "40": relay five off
      put_char(CHAR_CR);
      put_char(8'h0B);
      put_char(CHAR_ZERO + 8'd4);
      put_char(CHAR_ZERO);
      put_char(CHAR_STAR);
      // " 11/": relay eight on
      put_char(CHAR_SPACE);
      put_char(CHAR_ZERO + 8'd1);
      put_char(CHAR_ZERO + 8'd1);
      put_char(CHAR_SLASH);
      // leading minus: the token does nothing
      put_char(CHAR_MINUS);
      put_char(CHAR_ZERO + 8'd2);
      put_char(CHAR_ZERO + 8'd1);
      put_char(CHAR_SLASH);
      // empty token selects no relay
      put_char(CHAR_SLASH);
      // NUL ends the digit run, the trailing 9 is ignored: "31" turns relay six on
      put_char(CHAR_ZERO + 8'd3);
      put_char(CHAR_ZERO + 8'd1);
      put_char(8'h00);
      put_char(CHAR_ZERO + 8'd9);
      put_char(CHAR_SLASH);
      // 0xFF after "2": code 0, no report
      put_char(CHAR_ZERO + 8'd2);
      put_char(8'hFF);
      put_char(CHAR_STAR);
      // all four buttons pressed at once, held, released, then two pressed again
      put_word(MODE_BUTTON, 8'hFF, 4'h0);
      put_word(MODE_BUTTON, 8'h00, 4'h0);
      put_word(MODE_BUTTON, 8'h2F, 4'hF);
      put_word(MODE_BUTTON, 8'h2A, 4'b0110);
      hold_until_drained();

      // Random part: mostly well-formed tokens, button samples, some raw noise.
      while (words_sent < RANDOM_WORDS) begin
         pick = $urandom_range(0, 99);
         if (pick < 65)
            send_token();
         else if (pick < 90)
            put_word(MODE_BUTTON, 8'($urandom), 4'($urandom));
         else
            put_word(MODE_SERIAL, 8'($urandom), 4'($urandom));
         if (!paused && words_sent >= RANDOM_WORDS / 2) begin
            paused = 1;
            hold_until_drained();
         end
      end

      // Wind down: let every predicted word arrive, then watch for strays.
      hold_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d words (serial tokens, noise and button samples); checked %0d",
               words_sent, board.n_checked);
      $display("report words from %0d predicted reports, %0d mismatches",
               board.n_reports, board.n_errors);
      if (board.n_errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
